// ===== design/iira_pkg.sv =====
`timescale 1ns / 1ps

package iira_pkg;

  localparam int unsigned CMD_BITS   = 2;
  localparam int unsigned POS_BITS   = 4;
  localparam int unsigned CNT_BITS   = 5;
  localparam int unsigned FIELD_BITS = 32;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SET    = 2'd2,
    CMD_GET    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_SET
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [POS_BITS-1:0] pos;
  } cell_ctrl_t;

endpackage

// ===== design/iira_cell.sv =====
`timescale 1ns / 1ps

module iira_cell import iira_pkg::*; #(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [WORD_BITS-1:0] load_word,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  input  logic [WORD_BITS-1:0] rd_in,
  output logic [WORD_BITS-1:0] word,
  output logic [WORD_BITS-1:0] rd_out
);

  logic at_pos;
  logic past_pos;

  assign at_pos   = (INDEX == 32'(ctrl.pos));
  assign past_pos = (INDEX > 32'(ctrl.pos));

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (at_pos) begin
          word <= load_word;
        end else if (past_pos) begin
          word <= left_word;
        end
      end
      OP_REMOVE: begin
        if (at_pos || past_pos) begin
          word <= right_word;
        end
      end
      OP_SET: begin
        if (at_pos) begin
          word <= load_word;
        end
      end
      default: begin
      end
    endcase
  end

  // read data collected along the row
  assign rd_out = at_pos ? word : rd_in;

endmodule

// ===== design/indexed_insert_remove_array_top.sv =====
`timescale 1ns / 1ps
// a result is registered at the edge of its request transfer
// throughput: one request per cycle when not stalled; each cell shifts, loads or holds
// reset: live count cleared to zero, capacity set to 16, no result pending
// entry contents are not reset and are only read below the live count

module indexed_insert_remove_array_top import iira_pkg::*; #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  capacity_we,
  input  logic [CNT_BITS-1:0]   capacity_wdata,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [CMD_BITS-1:0]   cmd,
  input  logic [POS_BITS-1:0]   position,
  input  logic [FIELD_BITS-1:0] value,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  ok,
  output logic [FIELD_BITS-1:0] read_value,
  output logic [CNT_BITS-1:0]   count,
  output logic                  is_full,
  output logic                  is_empty
);

  localparam logic [CNT_BITS:0] DEPTH_LIM =
    (DEPTH >= (1 << CNT_BITS)) ? (CNT_BITS+1)'(1 << CNT_BITS) : (CNT_BITS+1)'(DEPTH);

  logic [CNT_BITS-1:0]  capacity;
  logic [CNT_BITS-1:0]  live_count;
  logic [CNT_BITS-1:0]  live_count_next;
  logic [CNT_BITS-1:0]  cap;
  logic [CNT_BITS-1:0]  pos_ext;
  logic                 accept;
  logic                 ins_ok;
  logic                 other_ok;
  logic                 req_ok;
  cmd_t                 req_cmd;
  cell_ctrl_t           ctrl;
  logic [WORD_BITS-1:0] load_word;
  logic [WORD_BITS-1:0] rd_word;

  logic [FIELD_BITS+WORD_BITS-1:0] value_ext;
  logic [FIELD_BITS+WORD_BITS-1:0] rd_ext;

  logic [WORD_BITS-1:0] cell_word [DEPTH];
  logic [WORD_BITS-1:0] rd_chain  [DEPTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_BITS'(16);
    end else if (capacity_we) begin
      capacity <= capacity_wdata;
    end
  end

  always_comb begin
    if (capacity == '0) begin
      cap = CNT_BITS'(1);
    end else if ({1'b0, capacity} > DEPTH_LIM) begin
      cap = DEPTH_LIM[CNT_BITS-1:0];
    end else begin
      cap = capacity;
    end
  end

  assign accept  = req_valid && !req_stall;
  assign req_cmd = cmd_t'(cmd);
  assign pos_ext = CNT_BITS'(position);

  assign ins_ok   = (live_count < cap) && (pos_ext <= live_count) && (pos_ext != cap);
  assign other_ok = (pos_ext < live_count) && (pos_ext != cap);
  assign req_ok   = (req_cmd == CMD_INSERT) ? ins_ok : other_ok;

  always_comb begin
    ctrl.pos        = position;
    ctrl.op         = OP_HOLD;
    live_count_next = live_count;
    if (accept && req_ok) begin
      case (req_cmd)
        CMD_INSERT: begin
          ctrl.op         = OP_INSERT;
          live_count_next = live_count + CNT_BITS'(1);
        end
        CMD_REMOVE: begin
          ctrl.op         = OP_REMOVE;
          live_count_next = live_count - CNT_BITS'(1);
        end
        CMD_SET: begin
          ctrl.op = OP_SET;
        end
        default: begin
          ctrl.op = OP_HOLD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
    end else begin
      live_count <= live_count_next;
    end
  end

  assign value_ext = {{WORD_BITS{1'b0}}, value};
  assign load_word = value_ext[WORD_BITS-1:0];

  assign rd_chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_word;
    logic [WORD_BITS-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid
      assign left_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner
      assign right_word = cell_word[i+1];
    end

    iira_cell #(
      .INDEX     (i),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_word  (load_word),
      .left_word  (left_word),
      .right_word (right_word),
      .rd_in      (rd_chain[i]),
      .word       (cell_word[i]),
      .rd_out     (rd_chain[i+1])
    );
  end

  assign rd_word = (req_ok && (req_cmd == CMD_GET)) ? rd_chain[DEPTH] : '0;
  assign rd_ext  = {{FIELD_BITS{1'b0}}, rd_word};

  // output register, refilled on the same edge it is taken
  assign req_stall = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok         <= req_ok;
      read_value <= rd_ext[FIELD_BITS-1:0];
      count      <= live_count_next;
      is_full    <= (live_count_next >= cap);
      is_empty   <= (live_count_next == '0);
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import iira_pkg::*;

  localparam int DEPTH   = 16;
  localparam int HOLD_CY = 60;

  typedef struct packed {
    cmd_t                  cmd;
    logic [POS_BITS-1:0]   pos;
    logic [FIELD_BITS-1:0] val;
  } array_req_t;

  typedef struct packed {
    logic                  ok;
    logic [FIELD_BITS-1:0] rd;
    logic [CNT_BITS-1:0]   cnt;
    logic                  full;
    logic                  empty;
  } array_rsp_t;

  typedef struct packed {
    logic [DEPTH-1:0][FIELD_BITS-1:0] ent;
    logic [CNT_BITS-1:0]              cnt;
    logic [CNT_BITS-1:0]              cap;
  } array_state_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  capacity_we = 1'b0;
  logic [CNT_BITS-1:0]   capacity_wdata = '0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [CMD_BITS-1:0]   cmd = '0;
  logic [POS_BITS-1:0]   position = '0;
  logic [FIELD_BITS-1:0] value = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic                  ok;
  logic [FIELD_BITS-1:0] read_value;
  logic [CNT_BITS-1:0]   count;
  logic                  is_full;
  logic                  is_empty;

  array_req_t   pending_req_q[$];
  array_rsp_t   expected_rsp_q[$];
  array_state_t model_st;
  array_state_t plan_st;
  array_req_t   drive_req;
  array_req_t   taken_req;
  array_rsp_t   pred_rsp;
  array_rsp_t   want_rsp;
  array_rsp_t   seen_rsp;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_on = 1'b0;
  int           bad_count = 0;
  int           tide_left = 8;
  bit           filling = 1'b1;

  indexed_insert_remove_array_top dut (
    .clk           (clk),
    .rst           (rst),
    .capacity_we   (capacity_we),
    .capacity_wdata(capacity_wdata),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .cmd           (cmd),
    .position      (position),
    .value         (value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .ok            (ok),
    .read_value    (read_value),
    .count         (count),
    .is_full       (is_full),
    .is_empty      (is_empty)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void step_array(inout array_state_t st, input array_req_t rq,
                                     output array_rsp_t rs);
    logic [CNT_BITS-1:0] eff;
    int                  i;
    eff = (st.cap == 0) ? CNT_BITS'(1) : (st.cap > DEPTH) ? CNT_BITS'(DEPTH) : st.cap;
    rs.ok = 1'b0;
    rs.rd = '0;
    if (rq.cmd == CMD_INSERT) begin
      if (st.cnt < eff && rq.pos <= st.cnt && {1'b0, rq.pos} != eff && st.cnt < DEPTH) begin
        for (i = st.cnt; i > rq.pos; i--) st.ent[i] = st.ent[i-1];
        st.ent[rq.pos] = rq.val;
        st.cnt = st.cnt + 1'b1;
        rs.ok = 1'b1;
      end
    end else if (rq.pos < st.cnt && {1'b0, rq.pos} != eff) begin
      rs.ok = 1'b1;
      case (rq.cmd)
        CMD_REMOVE: begin
          for (i = rq.pos; i + 1 < st.cnt; i++) st.ent[i] = st.ent[i+1];
          st.cnt = st.cnt - 1'b1;
        end
        CMD_SET: st.ent[rq.pos] = rq.val;
        default: rs.rd = st.ent[rq.pos];
      endcase
    end
    rs.cnt   = st.cnt;
    rs.full  = (st.cnt >= eff);
    rs.empty = (st.cnt == 0);
  endfunction

  function automatic array_req_t mk_req(input cmd_t c, input int p, input logic [31:0] v);
    array_req_t r;
    r.cmd = c;
    r.pos = POS_BITS'(p);
    r.val = v;
    return r;
  endfunction

  task automatic push_req(input array_req_t r);
    array_rsp_t scratch;
    step_array(plan_st, r, scratch);
    pending_req_q.push_back(r);
  endtask

  task automatic add_random();
    array_req_t r;
    int         roll;
    int         ins_w;
    int         top;
    if (tide_left == 0) begin
      filling   = !filling;
      tide_left = $urandom_range(4, 24);
    end
    tide_left--;
    ins_w = filling ? 55 : 15;
    roll  = $urandom_range(0, 99);
    if (roll < ins_w) r.cmd = CMD_INSERT;
    else if (roll < 70) r.cmd = CMD_REMOVE;
    else if (roll < 82) r.cmd = CMD_SET;
    else r.cmd = CMD_GET;
    roll = $urandom_range(0, 99);
    if (r.cmd == CMD_INSERT && roll < 80) begin
      top   = (plan_st.cnt > 15) ? 15 : plan_st.cnt;
      r.pos = POS_BITS'($urandom_range(0, top));
    end else if (r.cmd != CMD_INSERT && roll < 80 && plan_st.cnt > 0) begin
      top   = (plan_st.cnt > 16) ? 16 : plan_st.cnt;
      r.pos = POS_BITS'($urandom_range(0, top - 1));
    end else begin
      r.pos = POS_BITS'($urandom_range(0, 15));
    end
    roll = $urandom_range(0, 9);
    r.val = (roll == 0) ? '0 : (roll == 1) ? '1 : FIELD_BITS'($urandom);
    push_req(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_BITS-1:0] v);
    @(posedge clk);
    capacity_wdata <= v;
    capacity_we    <= 1'b1;
    @(posedge clk);
    capacity_we    <= 1'b0;
    model_st.cap = v;
  endtask

  task automatic start_phase(input logic [CNT_BITS-1:0] cap_v, input int send_pct,
                             input int stall_pct);
    wait_idle();
    write_capacity(cap_v);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    plan_st        = model_st;
  endtask

  task automatic report_bad(input string what, input array_rsp_t e, input array_rsp_t g);
    if (bad_count < 10)
      $display("%s: exp ok=%0d rd=%h cnt=%0d full=%0d empty=%0d got ok=%0d rd=%h cnt=%0d full=%0d empty=%0d",
               what, e.ok, e.rd, e.cnt, e.full, e.empty, g.ok, g.rd, g.cnt, g.full, g.empty);
    bad_count++;
  endtask

  // request driver and predictor
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        taken_req.cmd = cmd_t'(cmd);
        taken_req.pos = position;
        taken_req.val = value;
        step_array(model_st, taken_req, pred_rsp);
        expected_rsp_q.push_back(pred_rsp);
      end
      if (req_valid && req_stall) begin
        req_valid <= 1'b1;
      end else if (pending_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_req = pending_req_q.pop_front();
        cmd       <= drive_req.cmd;
        position  <= drive_req.pos;
        value     <= drive_req.val;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        seen_rsp.ok    = ok;
        seen_rsp.rd    = read_value;
        seen_rsp.cnt   = count;
        seen_rsp.full  = is_full;
        seen_rsp.empty = is_empty;
        if (expected_rsp_q.size() == 0) begin
          report_bad("unexpected transfer", '0, seen_rsp);
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          if (seen_rsp.ok !== want_rsp.ok || seen_rsp.rd !== want_rsp.rd ||
              seen_rsp.cnt !== want_rsp.cnt || seen_rsp.full !== want_rsp.full ||
              seen_rsp.empty !== want_rsp.empty)
            report_bad("mismatch", want_rsp, seen_rsp);
        end
      end
      rsp_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    #200000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    model_st.ent = '0;
    model_st.cnt = '0;
    model_st.cap = CNT_BITS'(16);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    plan_st = model_st;

    // empty list and reset capacity
    push_req(mk_req(CMD_GET,    0, 32'h0));
    push_req(mk_req(CMD_REMOVE, 0, 32'h0));
    push_req(mk_req(CMD_SET,    0, 32'hFFFFFFFF));
    push_req(mk_req(CMD_INSERT, 1, 32'h11111111));
    push_req(mk_req(CMD_INSERT, 0, 32'hFFFFFFFF));
    push_req(mk_req(CMD_INSERT, 0, 32'h00000000));
    push_req(mk_req(CMD_INSERT, 2, 32'hA5A5A5A5));
    push_req(mk_req(CMD_INSERT, 1, 32'h5A5A5A5A));
    push_req(mk_req(CMD_GET,    0, 32'hFFFFFFFF));
    push_req(mk_req(CMD_GET,    1, 32'h0));
    push_req(mk_req(CMD_GET,    2, 32'h0));
    push_req(mk_req(CMD_GET,    3, 32'h0));
    push_req(mk_req(CMD_GET,    4, 32'h0));
    push_req(mk_req(CMD_SET,    2, 32'h12345678));
    push_req(mk_req(CMD_GET,    2, 32'h0));
    push_req(mk_req(CMD_REMOVE, 4, 32'h0));
    push_req(mk_req(CMD_REMOVE, 0, 32'h0));
    push_req(mk_req(CMD_GET,    0, 32'h0));
    push_req(mk_req(CMD_REMOVE, 2, 32'h0));
    push_req(mk_req(CMD_GET,    1, 32'h0));
    push_req(mk_req(CMD_INSERT, 15, 32'hDEADBEEF));
    push_req(mk_req(CMD_SET,    15, 32'hFFFFFFFF));
    push_req(mk_req(CMD_REMOVE, 1, 32'h0));
    push_req(mk_req(CMD_REMOVE, 0, 32'h0));
    push_req(mk_req(CMD_INSERT, 0, 32'h80000001));

    start_phase(CNT_BITS'(16), 0, 0);
    repeat (150) add_random();

    start_phase(CNT_BITS'(1), 47, 0);
    repeat (100) add_random();

    // zero acts as one
    start_phase(CNT_BITS'(0), 0, 47);
    repeat (60) add_random();

    // above depth acts as depth
    start_phase(CNT_BITS'(31), 35, 35);
    repeat (150) add_random();
    repeat (16) push_req(mk_req(CMD_INSERT, plan_st.cnt, $urandom));

    // capacity lowered below the live count
    start_phase(CNT_BITS'(5), 35, 35);
    push_req(mk_req(CMD_INSERT, 0, 32'hCAFEF00D));
    push_req(mk_req(CMD_GET,    5, 32'h0));
    push_req(mk_req(CMD_GET,    6, 32'h0));
    push_req(mk_req(CMD_SET,    15, 32'h0F0F0F0F));
    push_req(mk_req(CMD_GET,    15, 32'h0));
    push_req(mk_req(CMD_REMOVE, 5, 32'h0));
    push_req(mk_req(CMD_REMOVE, 15, 32'h0));
    repeat (120) add_random();

    // receiver holds off while the sender keeps offering
    start_phase(CNT_BITS'(8), 0, 47);
    repeat (150) add_random();
    fork
      begin
        hold_on = 1'b1;
        repeat (HOLD_CY) @(negedge clk);
        hold_on = 1'b0;
      end
    join_none

    start_phase(CNT_BITS'(12), 0, 0);
    repeat (100) add_random();

    start_phase(CNT_BITS'(16), 35, 35);
    repeat (120) add_random();

    wait_idle();
    repeat (5) @(posedge clk);
    if (bad_count == 0 && expected_rsp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
